@@ hw/rtl/cmt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmt_pkg
// Shared types and command codes for the channel membership table.
// ----------------------------------------------------------------------------
package cmt_pkg;

  // Fixed field widths
  localparam int ID_W    = 16;
  localparam int COUNT_W = 16;
  localparam int CMD_W   = 4;
  localparam int LIDX_W  = 3;

  typedef logic [CMD_W-1:0]   cmd_t;
  typedef logic [ID_W-1:0]    chan_id_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [LIDX_W-1:0]  load_idx_t;

  // Command codes
  localparam cmd_t CMD_QUERY      = 4'd0;
  localparam cmd_t CMD_JOIN       = 4'd1;
  localparam cmd_t CMD_LEAVE      = 4'd2;
  localparam cmd_t CMD_SET_MUTED  = 4'd3;
  localparam cmd_t CMD_SET_HIDDEN = 4'd4;
  localparam cmd_t CMD_SET_TXDEF  = 4'd5;
  localparam cmd_t CMD_MARK_UNRD  = 4'd6;
  localparam cmd_t CMD_CLR_UNRD   = 4'd7;
  localparam cmd_t CMD_LOAD_SLOT  = 4'd8;

endpackage

@@ hw/rtl/channel_membership_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_membership_table_top
// Slot table of channel ids with join/mute/hide/unread state and a
// transmit-default slot; one command in, one status result out.
// ----------------------------------------------------------------------------
// Takes one command transaction per clock while no stall holds it and returns
// one result for each: the input register captures the command at the
// accepting edge and the result register loads when it is free. All
// SLOT_COUNT id comparators, the first-match select and the slot update sit
// in one combinational pass between those registers, so commands that hit
// the same slot back to back see each other's updates. A stalled result
// blocks new commands only once the input register also holds one; then
// in_stall stays high until the result is taken. A channel id resolves to
// the lowest named slot that holds it; id 0 falls back to slot 0.
// Unknown ids report found=0 and hidden=1.
module channel_membership_table_top #(
  parameter int SLOT_COUNT  = 8,
  parameter int UNREAD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // command channel
  input  logic                in_valid,
  output logic                in_stall,
  input  cmt_pkg::cmd_t       in_command,
  input  cmt_pkg::chan_id_t   in_channel_id,
  input  logic                in_flag_value,
  input  cmt_pkg::load_idx_t  in_load_index,
  input  logic                in_load_named,
  input  logic                in_load_priority,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_found,
  output logic                out_is_joined,
  output logic                out_is_muted,
  output logic                out_is_hidden,
  output logic                out_is_priority,
  output cmt_pkg::count_t     out_unread_count,
  output logic                out_accepted,
  output cmt_pkg::chan_id_t   out_tx_default_id
);
  import cmt_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);

  typedef logic [IDX_W-1:0]       slot_idx_t;
  typedef logic [UNREAD_BITS-1:0] unread_t;

  // Handshake / pipeline control
  logic in_vld_r;
  logic out_valid_r;
  logic advance;
  logic in_take;
  logic fire;

  // Input register
  cmd_t      in_cmd_r;
  chan_id_t  in_id_r;
  logic      in_flag_r;
  load_idx_t in_lidx_r;
  logic      in_lnamed_r;
  logic      in_lprio_r;

  // Slot state
  chan_id_t              slot_id_r  [SLOT_COUNT];
  chan_id_t              slot_id_nxt[SLOT_COUNT];
  unread_t               unread_r   [SLOT_COUNT];
  unread_t               unread_nxt [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] named_r,  named_nxt;
  logic [SLOT_COUNT-1:0] prio_r,   prio_nxt;
  logic [SLOT_COUNT-1:0] joined_r, joined_nxt;
  logic [SLOT_COUNT-1:0] muted_r,  muted_nxt;
  logic [SLOT_COUNT-1:0] hidden_r, hidden_nxt;
  slot_idx_t             txdef_r,  txdef_nxt;

  // Lookup and result
  logic      hit;
  slot_idx_t slot;
  logic      acc;

  // Result register
  logic     out_found_r, out_joined_r, out_muted_r, out_hidden_r, out_prio_r;
  logic     out_acc_r;
  count_t   out_unread_r;
  chan_id_t out_txid_r;

  // Flow control: result register frees when empty or taken
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;
  assign fire     = in_vld_r && advance;

  // Command execution: load write, lookup, then slot update
  always_comb begin
    slot_id_nxt = slot_id_r;
    unread_nxt  = unread_r;
    named_nxt   = named_r;
    prio_nxt    = prio_r;
    joined_nxt  = joined_r;
    muted_nxt   = muted_r;
    hidden_nxt  = hidden_r;
    txdef_nxt   = txdef_r;
    hit         = 1'b0;
    slot        = '0;
    acc         = 1'b0;

    // load_slot writes before the lookup so the result sees the new entry
    if (in_cmd_r == CMD_LOAD_SLOT) begin
      for (int j = 0; j < SLOT_COUNT; j++) begin
        if (32'(in_lidx_r) == j) begin
          slot_id_nxt[j] = in_id_r;
          named_nxt[j]   = in_lnamed_r;
          prio_nxt[j]    = in_lprio_r;
          acc            = 1'b1;
        end
      end
    end

    // lowest named slot holding the id wins
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (named_nxt[i] && (slot_id_nxt[i] == in_id_r)) begin
        hit  = 1'b1;
        slot = IDX_W'(i);
      end
    end
    // id 0 falls back to slot 0
    if (!hit && (in_id_r == '0)) begin
      hit = 1'b1;
    end

    case (in_cmd_r)
      CMD_QUERY: begin
        acc = hit;
      end
      CMD_JOIN: begin
        if (hit) begin
          joined_nxt[slot] = 1'b1;
          acc              = 1'b1;
        end
      end
      CMD_LEAVE: begin
        // leave of id 0 is refused
        if (hit && (in_id_r != '0)) begin
          joined_nxt[slot] = 1'b0;
          if (txdef_r == slot) begin
            txdef_nxt = '0;
          end
          acc = 1'b1;
        end
      end
      CMD_SET_MUTED: begin
        if (hit) begin
          muted_nxt[slot] = in_flag_r;
          acc             = 1'b1;
        end
      end
      CMD_SET_HIDDEN: begin
        if (hit) begin
          hidden_nxt[slot] = in_flag_r;
          acc              = 1'b1;
        end
      end
      CMD_SET_TXDEF: begin
        if (hit && joined_r[slot]) begin
          txdef_nxt = slot;
          acc       = 1'b1;
        end
      end
      CMD_MARK_UNRD: begin
        // skipped when muted, saturates at all ones
        if (hit && !muted_r[slot]) begin
          if (unread_r[slot] != {UNREAD_BITS{1'b1}}) begin
            unread_nxt[slot] = unread_r[slot] + UNREAD_BITS'(1);
          end
          acc = 1'b1;
        end
      end
      CMD_CLR_UNRD: begin
        if (hit) begin
          unread_nxt[slot] = '0;
          acc              = 1'b1;
        end
      end
      CMD_LOAD_SLOT: begin
        // write handled above
      end
      default: begin
        // unknown command: lookup only
      end
    endcase
  end

  // Control and slot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      txdef_r     <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_id_r[i] <= ID_W'(i);
        unread_r[i]  <= '0;
        named_r[i]   <= (i < 4);
        prio_r[i]    <= (i == 3);
        joined_r[i]  <= (i == 0) || (i == 1) || (i == 3);
        muted_r[i]   <= 1'b0;
        hidden_r[i]  <= (i >= 4);
      end
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= in_vld_r;
      end
      if (fire) begin
        slot_id_r <= slot_id_nxt;
        unread_r  <= unread_nxt;
        named_r   <= named_nxt;
        prio_r    <= prio_nxt;
        joined_r  <= joined_nxt;
        muted_r   <= muted_nxt;
        hidden_r  <= hidden_nxt;
        txdef_r   <= txdef_nxt;
      end
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_cmd_r    <= in_command;
      in_id_r     <= in_channel_id;
      in_flag_r   <= in_flag_value;
      in_lidx_r   <= in_load_index;
      in_lnamed_r <= in_load_named;
      in_lprio_r  <= in_load_priority;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_found_r  <= hit;
      out_joined_r <= hit && joined_nxt[slot];
      out_muted_r  <= hit && muted_nxt[slot];
      out_hidden_r <= !hit || hidden_nxt[slot];
      out_prio_r   <= hit && prio_nxt[slot];
      out_unread_r <= hit ? COUNT_W'(unread_nxt[slot]) : '0;
      out_acc_r    <= acc;
      out_txid_r   <= slot_id_nxt[txdef_nxt];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_is_joined     = out_joined_r;
  assign out_is_muted      = out_muted_r;
  assign out_is_hidden     = out_hidden_r;
  assign out_is_priority   = out_prio_r;
  assign out_unread_count  = out_unread_r;
  assign out_accepted      = out_acc_r;
  assign out_tx_default_id = out_txid_r;

  // Transmit default always points at an existing slot
  a_txdef_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(txdef_r) < SLOT_COUNT)
    else $error("transmit default index out of range");

  // Result register drains when taken with nothing behind it
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !in_vld_r |=> !out_valid_r)
    else $error("result appeared without a command");

  // Held command stays put while the result side is blocked
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(in_cmd_r) && $stable(in_id_r))
    else $error("pending command lost while stalled");

  // Unknown channel reports the fixed miss pattern
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |->
      out_hidden_r && !out_joined_r && !out_muted_r && !out_prio_r &&
      (out_unread_r == '0))
    else $error("miss result carries slot data");

endmodule

@@ verif/channel_membership_table_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_membership_table_top_tb
// Self-checking bench for the channel membership table.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the eight-slot table and predicts the
// status of every accepted command transaction. Results are compared field
// by field in order. Stimulus is a directed pass over every command and the
// corner cases, a back-to-back run of unread marks on one slot, then random
// command mixes with random gaps on both channels.
// ----------------------------------------------------------------------------
import cmt_pkg::*;

typedef struct packed {
  logic     found;
  logic     joined;
  logic     muted;
  logic     hidden;
  logic     prio;
  count_t   unread;
  logic     accepted;
  chan_id_t txdef_id;
} table_status_t;

class membership_scoreboard;
  localparam int NSLOTS = 8;

  chan_id_t    ids[NSLOTS];
  bit          named[NSLOTS];
  bit          prio[NSLOTS];
  bit          joined[NSLOTS];
  bit          muted[NSLOTS];
  bit          hidden[NSLOTS];
  bit          txdef[NSLOTS];
  count_t      unread[NSLOTS];
  int unsigned txdef_idx;

  table_status_t pending_status[$];
  int unsigned   fail_count;
  int unsigned   noted_count;
  int unsigned   checked_count;
  int unsigned   accepted_count;
  int unsigned   saturated_count;

  // table contents right after reset
  function new();
    for (int i = 0; i < NSLOTS; i++) begin
      ids[i]    = chan_id_t'(i);
      named[i]  = (i < 4);
      prio[i]   = (i == 3);
      joined[i] = (i == 0 || i == 1 || i == 3);
      muted[i]  = 1'b0;
      hidden[i] = (i >= 4);
      txdef[i]  = (i == 0);
      unread[i] = '0;
    end
    txdef_idx = 0;
  endfunction

  // lowest named slot holding the id; id 0 falls back to slot 0
  function int unsigned resolve_slot(chan_id_t id);
    for (int i = 0; i < NSLOTS; i++) begin
      if (named[i] && ids[i] == id) return i;
    end
    return (id == '0) ? 0 : NSLOTS;
  endfunction

  // apply one accepted command and queue the status it must produce
  function void note_command(cmd_t c, chan_id_t id, bit f, load_idx_t li, bit ln, bit lp);
    int unsigned   s;
    bit            hit;
    bit            acc;
    table_status_t st;
    s   = resolve_slot(id);
    hit = (s < NSLOTS);
    acc = 1'b0;
    noted_count++;
    case (c)
      CMD_QUERY: acc = hit;
      CMD_JOIN: if (hit) begin
        joined[s] = 1'b1;
        acc = 1'b1;
      end
      CMD_LEAVE: if (hit && id != '0) begin
        joined[s] = 1'b0;
        // leaving the transmit default hands it back to slot 0
        if (txdef[s]) begin
          txdef[s]  = 1'b0;
          txdef[0]  = 1'b1;
          txdef_idx = 0;
        end
        acc = 1'b1;
      end
      CMD_SET_MUTED: if (hit) begin
        muted[s] = f;
        acc = 1'b1;
      end
      CMD_SET_HIDDEN: if (hit) begin
        hidden[s] = f;
        acc = 1'b1;
      end
      CMD_SET_TXDEF: if (hit && joined[s]) begin
        foreach (txdef[j]) txdef[j] = 1'b0;
        txdef[s]  = 1'b1;
        txdef_idx = s;
        acc = 1'b1;
      end
      CMD_MARK_UNRD: if (hit && !muted[s]) begin
        if (unread[s] != '1) unread[s]++;
        else saturated_count++;
        acc = 1'b1;
      end
      CMD_CLR_UNRD: if (hit) begin
        unread[s] = '0;
        acc = 1'b1;
      end
      CMD_LOAD_SLOT: begin
        ids[li]   = id;
        named[li] = ln;
        prio[li]  = lp;
        acc = 1'b1;
        s   = resolve_slot(id);
        hit = (s < NSLOTS);
      end
      default: ;
    endcase

    if (hit) begin
      st.found  = 1'b1;
      st.joined = joined[s];
      st.muted  = muted[s];
      st.hidden = hidden[s];
      st.prio   = prio[s];
      st.unread = unread[s];
    end else begin
      st.found  = 1'b0;
      st.joined = 1'b0;
      st.muted  = 1'b0;
      st.hidden = 1'b1;
      st.prio   = 1'b0;
      st.unread = '0;
    end
    st.accepted = acc;
    st.txdef_id = ids[txdef_idx];
    if (acc) accepted_count++;
    pending_status.push_back(st);
  endfunction

  function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  // compare one result against the oldest pending status
  function void check_status(table_status_t got);
    table_status_t exp_st;
    checked_count++;
    if (pending_status.size() == 0) begin
      $error("result transaction with no command pending");
      fail_count++;
      return;
    end
    exp_st = pending_status.pop_front();
    compare_field("found",         exp_st.found,    got.found);
    compare_field("is_joined",     exp_st.joined,   got.joined);
    compare_field("is_muted",      exp_st.muted,    got.muted);
    compare_field("is_hidden",     exp_st.hidden,   got.hidden);
    compare_field("is_priority",   exp_st.prio,     got.prio);
    compare_field("unread_count",  exp_st.unread,   got.unread);
    compare_field("accepted",      exp_st.accepted, got.accepted);
    compare_field("tx_default_id", exp_st.txdef_id, got.txdef_id);
  endfunction
endclass

module channel_membership_table_top_tb;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 440;
  localparam int SEGMENTS     = 5;
  localparam int UNREAD_RUN   = 40;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  cmd_t      in_command;
  chan_id_t  in_channel_id;
  logic      in_flag_value;
  load_idx_t in_load_index;
  logic      in_load_named;
  logic      in_load_priority;
  logic      out_valid;
  logic      out_stall = 1'b0;
  logic      out_found;
  logic      out_is_joined;
  logic      out_is_muted;
  logic      out_is_hidden;
  logic      out_is_priority;
  count_t    out_unread_count;
  logic      out_accepted;
  chan_id_t  out_tx_default_id;

  membership_scoreboard sb;
  bit          tx_idle;
  bit          rx_idle;
  int          rx_hold = 0;
  int          rx_pick;
  int unsigned cycle_count = 0;

  channel_membership_table_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_channel_id     (in_channel_id),
    .in_flag_value     (in_flag_value),
    .in_load_index     (in_load_index),
    .in_load_named     (in_load_named),
    .in_load_priority  (in_load_priority),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_is_joined     (out_is_joined),
    .out_is_muted      (out_is_muted),
    .out_is_hidden     (out_is_hidden),
    .out_is_priority   (out_is_priority),
    .out_unread_count  (out_unread_count),
    .out_accepted      (out_accepted),
    .out_tx_default_id (out_tx_default_id)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("channel_membership_table_top_tb: FAIL");
      $finish;
    end
  end

  // monitor: note accepted commands first, then check results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_command(in_command, in_channel_id, in_flag_value, in_load_index,
                        in_load_named, in_load_priority);
      if (out_valid && !out_stall)
        sb.check_status({out_found, out_is_joined, out_is_muted, out_is_hidden,
                         out_is_priority, out_unread_count, out_accepted,
                         out_tx_default_id});
    end
  end

  // result-side backpressure: runs of ready, short stalls, rare long stalls
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
    end else if (!rx_idle) begin
      out_stall = 1'b0;
    end else begin
      rx_pick = $urandom_range(0, 99);
      if (rx_pick < 55) begin
        out_stall = 1'b0;
        rx_hold   = $urandom_range(0, 6);
      end else if (rx_pick < 92) begin
        out_stall = 1'b1;
        rx_hold   = $urandom_range(0, 2);
      end else begin
        out_stall = 1'b1;
        rx_hold   = $urandom_range(8, 30);
      end
    end
  end

  // one command transaction; called and returns at a falling edge
  task automatic send_cmd(cmd_t c, chan_id_t id, logic f = 1'b0, load_idx_t li = '0,
                          logic ln = 1'b0, logic lp = 1'b0);
    int gap;
    int pick;
    gap = 0;
    if (tx_idle) begin
      pick = $urandom_range(0, 99);
      if (pick >= 90) gap = $urandom_range(8, 30);
      else if (pick >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         = 1'b1;
    in_command       = c;
    in_channel_id    = id;
    in_flag_value    = f;
    in_load_index    = li;
    in_load_named    = ln;
    in_load_priority = lp;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // hold off the sender until every pending status has come back
  task automatic drain_results();
    in_valid = 1'b0;
    while (sb.pending_status.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // random command mix; ids mostly taken from live slots so lookups hit
  task automatic run_random_segment(int count);
    int        done;
    int        pick;
    cmd_t      c;
    chan_id_t  id;
    load_idx_t li;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) c = cmd_t'($urandom_range(9, 15));
      else if (pick < 14) c = CMD_LOAD_SLOT;
      else c = cmd_t'($urandom_range(0, 7));
      li   = load_idx_t'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (c == CMD_LOAD_SLOT) begin
        if (pick < 50) id = chan_id_t'($urandom_range(0, 9));
        else if (pick < 70) id = sb.ids[$urandom_range(0, 7)];
        else if (pick < 85) id = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h8000;
        else id = chan_id_t'($urandom_range(0, 16'hFFFF));
      end else begin
        if (pick < 65) id = sb.ids[$urandom_range(0, 7)];
        else if (pick < 75) id = '0;
        else if (pick < 88) id = chan_id_t'($urandom_range(0, 15));
        else id = chan_id_t'($urandom_range(0, 16'hFFFF));
      end
      send_cmd(c, id, 1'($urandom_range(0, 1)), li,
               ($urandom_range(0, 3) != 0), 1'($urandom_range(0, 1)));
      // undefined codes only echo a lookup, so they do not count here
      if (c <= CMD_LOAD_SLOT) done++;
      if ($urandom_range(0, 59) == 0) drain_results();
    end
  endtask

  initial begin
    sb               = new();
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_command       = CMD_QUERY;
    in_channel_id    = '0;
    in_flag_value    = 1'b0;
    in_load_index    = '0;
    in_load_named    = 1'b0;
    in_load_priority = 1'b0;
    tx_idle          = 1'b0;
    rx_idle          = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: every command and the corner cases
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_cmd(CMD_QUERY, 16'd0);
    send_cmd(CMD_QUERY, 16'd3);                  // priority slot
    send_cmd(CMD_QUERY, 16'd4);                  // unnamed slot, unknown
    send_cmd(CMD_QUERY, 16'hFFFF);
    send_cmd(CMD_JOIN, 16'd2);
    send_cmd(CMD_SET_TXDEF, 16'd2);
    send_cmd(CMD_LEAVE, 16'd2);                  // default falls back to slot 0
    send_cmd(CMD_SET_TXDEF, 16'd2);              // not joined: refused
    send_cmd(CMD_LEAVE, 16'd0);                  // refused for id 0
    send_cmd(CMD_SET_MUTED, 16'd1, 1'b1);
    send_cmd(CMD_MARK_UNRD, 16'd1);              // muted: skipped
    send_cmd(CMD_SET_MUTED, 16'd1, 1'b0);
    send_cmd(CMD_MARK_UNRD, 16'd1);
    send_cmd(CMD_CLR_UNRD, 16'd1);
    send_cmd(CMD_SET_HIDDEN, 16'd3, 1'b1);
    send_cmd(CMD_SET_HIDDEN, 16'd3, 1'b0);
    send_cmd(CMD_LOAD_SLOT, 16'hFFFF, 1'b0, 3'd5, 1'b1, 1'b1);
    send_cmd(CMD_LOAD_SLOT, 16'hFFFF, 1'b1, 3'd7, 1'b1, 1'b0);  // shadowed by slot 5
    send_cmd(CMD_JOIN, 16'hFFFF);
    send_cmd(CMD_SET_TXDEF, 16'hFFFF);
    send_cmd(CMD_LOAD_SLOT, 16'h5A5A, 1'b0, 3'd0, 1'b0, 1'b0);
    send_cmd(CMD_QUERY, 16'd0);                  // id 0 fallback with slot 0 unnamed
    send_cmd(CMD_LOAD_SLOT, 16'd0, 1'b0, 3'd0, 1'b1, 1'b0);
    send_cmd(cmd_t'(9), 16'd1);
    send_cmd(cmd_t'(15), 16'hFFFF, 1'b1, 3'd7, 1'b1, 1'b1);
    drain_results();

    // unread marks on one slot, back to back
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_cmd(CMD_CLR_UNRD, 16'd1);
    repeat (UNREAD_RUN) send_cmd(CMD_MARK_UNRD, 16'd1);
    send_cmd(CMD_QUERY, 16'd1);
    send_cmd(CMD_CLR_UNRD, 16'd1);
    drain_results();

    // random segments with different idling on each side
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      tx_idle = (seg == 0 || seg == 2 || seg == 4);
      rx_idle = (seg == 0 || seg == 3 || seg == 4);
      run_random_segment(RANDOM_ITEMS / SEGMENTS);
      drain_results();
    end

    // let any stray result show up
    repeat (8) @(posedge clk);
    if (sb.pending_status.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_status.size());
      sb.fail_count++;
    end
    $display("Ran %0d commands across every operation and undefined codes.",
             sb.noted_count);
    $display("%0d results checked, %0d accepted, %0d marks at the unread ceiling.",
             sb.checked_count, sb.accepted_count, sb.saturated_count);
    if (sb.fail_count == 0) begin
      $display("channel_membership_table_top_tb: PASS");
    end else begin
      $display("channel_membership_table_top_tb: FAIL");
    end
    $finish;
  end
endmodule
